// ===== design/mss_pkg.sv =====
// shared types, constants and the remainder step function for the shard selector
// no dependencies
package mss_pkg;

	localparam int KEY_W          = 64;
	localparam int BYTE_W         = 8;
	localparam int REM_STAGES     = KEY_W / BYTE_W;
	localparam int WEIGHT_W       = 9;
	localparam int SHARD_W        = 16;
	localparam int SLOT_IDX_W     = 8;
	localparam int FIFO_DEPTH     = 4;
	localparam int DEF_SLOT_DEPTH = 256;
	localparam int DEF_SHARD_BITS = 16;

	// configuration register indexes
	localparam logic CFG_WEIGHT_TOTAL   = 1'b0;
	localparam logic CFG_KEY_WIDTH_MODE = 1'b1;

	// key width modes
	localparam logic [1:0] KEY_MODE_8  = 2'd0;
	localparam logic [1:0] KEY_MODE_16 = 2'd1;
	localparam logic [1:0] KEY_MODE_32 = 2'd2;
	localparam logic [1:0] KEY_MODE_64 = 2'd3;

	// item opcodes
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SELECT = 1'b1;

	// item travelling through the remainder pipeline
	typedef struct packed {
		logic                  sel;
		logic [SLOT_IDX_W-1:0] slot_index;
		logic [SHARD_W-1:0]    slot_shard;
		logic [KEY_W-1:0]      key;
		logic [WEIGHT_W-1:0]   rem;
		logic                  last;
	} fe_item_t;

	// item held in the queue between front and back
	typedef struct packed {
		logic                  sel;
		logic [SLOT_IDX_W-1:0] slot_index;
		logic [SHARD_W-1:0]    slot_shard;
		logic [WEIGHT_W-1:0]   rem;
		logic                  last;
	} q_item_t;

	// shifts one key byte into a running remainder, one restoring step per bit
	function automatic logic [WEIGHT_W-1:0] rem_byte(input logic [WEIGHT_W-1:0] r_in,
			input logic [BYTE_W-1:0] b, input logic [WEIGHT_W-1:0] w);
		logic [WEIGHT_W:0]   t;
		logic [WEIGHT_W-1:0] r;
		r = r_in;
		for (int j = BYTE_W - 1; j >= 0; j--) begin
			t = {r, b[j]};
			if (t >= {1'b0, w})
				t = t - {1'b0, w};
			r = t[WEIGHT_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== design/mss_if.sv =====
// input and output channel interfaces of the shard selector
// depends on mss_pkg for field widths
interface mss_in_if import mss_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  opcode;
	logic [SLOT_IDX_W-1:0] slot_index;
	logic [SHARD_W-1:0]    slot_shard;
	logic [KEY_W-1:0]      row_key;
	logic                  row_last;

	modport source (output valid, opcode, slot_index, slot_shard, row_key, row_last,
		input ready);
	modport sink (input valid, opcode, slot_index, slot_shard, row_key, row_last,
		output ready);
endinterface

interface mss_out_if import mss_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SHARD_W-1:0] shard_id;
	logic               last_out;

	modport source (output valid, shard_id, last_out, input ready);
	modport sink (input valid, shard_id, last_out, output ready);
endinterface

// ===== design/mss_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module mss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// ===== design/mss_front.sv =====
// front end: accepts items, masks the key and reduces it modulo the weight
// depends on mss_pkg and mss_if
module mss_front import mss_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	mss_in_if.sink              in_ch,
	input  logic [WEIGHT_W-1:0] weight_eff,
	input  logic [1:0]          key_mode,
	input  logic                q_full,
	output logic                q_push,
	output q_item_t             q_item
);

	logic     pipe_v_s    [REM_STAGES+1];
	fe_item_t pipe_item_s [REM_STAGES+1];
	fe_item_t stage_nxt   [REM_STAGES];
	logic     adv;
	logic [KEY_W-1:0] key_masked;
	fe_item_t in_item;

	// whole pipeline moves unless its last stage is blocked by a full queue
	assign adv         = !pipe_v_s[REM_STAGES] || !q_full;
	assign in_ch.ready = adv;
	assign q_push      = pipe_v_s[REM_STAGES] && !q_full;

	// key width masking, raw bits with no sign extension
	always_comb begin
		unique case (key_mode)
			KEY_MODE_8:  key_masked = {{(KEY_W-8){1'b0}}, in_ch.row_key[7:0]};
			KEY_MODE_16: key_masked = {{(KEY_W-16){1'b0}}, in_ch.row_key[15:0]};
			KEY_MODE_32: key_masked = {{(KEY_W-32){1'b0}}, in_ch.row_key[31:0]};
			KEY_MODE_64: key_masked = in_ch.row_key;
			default:     key_masked = in_ch.row_key;
		endcase
	end

	always_comb begin
		in_item.sel        = (in_ch.opcode == OP_SELECT);
		in_item.slot_index = in_ch.slot_index;
		in_item.slot_shard = in_ch.slot_shard;
		in_item.key        = key_masked;
		in_item.rem        = '0;
		in_item.last       = in_ch.row_last;
	end

	// next value of each remainder stage, one key byte each, most significant first
	always_comb begin
		for (int i = 0; i < REM_STAGES; i++) begin
			stage_nxt[i]     = pipe_item_s[i];
			stage_nxt[i].key = {pipe_item_s[i].key[KEY_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
			stage_nxt[i].rem = rem_byte(pipe_item_s[i].rem,
				pipe_item_s[i].key[KEY_W-1 -: BYTE_W], weight_eff);
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= REM_STAGES; i++)
				pipe_v_s[i] <= 1'b0;
		end else if (adv) begin
			pipe_v_s[0] <= in_ch.valid;
			for (int i = 0; i < REM_STAGES; i++)
				pipe_v_s[i+1] <= pipe_v_s[i];
		end
	end

	// entry stage and remainder stages
	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_item_s[0] <= in_item;
			for (int i = 0; i < REM_STAGES; i++)
				pipe_item_s[i+1] <= stage_nxt[i];
		end
	end

	// hand-off to the queue
	always_comb begin
		q_item.sel        = pipe_item_s[REM_STAGES].sel;
		q_item.slot_index = pipe_item_s[REM_STAGES].slot_index;
		q_item.slot_shard = pipe_item_s[REM_STAGES].slot_shard;
		q_item.rem        = pipe_item_s[REM_STAGES].rem;
		q_item.last       = pipe_item_s[REM_STAGES].last;
	end

endmodule

// ===== design/mss_fifo.sv =====
// short queue decoupling the remainder pipeline from the table access
// depends on mss_pkg
module mss_fifo import mss_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  q_item_t push_item,
	output logic    full,
	input  logic    pop,
	output q_item_t pop_item,
	output logic    empty
);

	localparam int PW = $clog2(FIFO_DEPTH);

	q_item_t       mem_q [FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full     = (count_q == (PW+1)'(FIFO_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

endmodule

// ===== design/mss_back.sv =====
// back end: applies loads to the slot table and looks up shards for selects
// depends on mss_pkg, mss_if and mss_ram
module mss_back import mss_pkg::*; #(
	parameter int SLOT_DEPTH = DEF_SLOT_DEPTH,
	parameter int SHARD_BITS = DEF_SHARD_BITS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_empty,
	input  q_item_t q_item,
	output logic    q_pop,
	mss_out_if.source out_ch
);

	localparam int AW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
	localparam int SW = (SHARD_BITS < SHARD_W) ? SHARD_BITS : SHARD_W;

	logic          rd_v_s1;
	logic          rd_last_s1;
	logic          rd_go;
	logic          ram_we;
	logic          ram_re;
	logic [SW-1:0] ram_rdata;
	logic          out_v_q;
	logic [SHARD_W-1:0] shard_q;
	logic          last_q;

	// lookup stage drains into the output register when that register is empty or being read
	assign rd_go  = rd_v_s1 && (!out_v_q || out_ch.ready);
	assign q_pop  = !q_empty && (!rd_v_s1 || rd_go);
	assign ram_re = q_pop && q_item.sel;
	assign ram_we = q_pop && !q_item.sel && ({24'd0, q_item.slot_index} < SLOT_DEPTH);

	mss_ram #(
		.WIDTH (SW),
		.DEPTH (SLOT_DEPTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(q_item.slot_index)),
		.wdata (SW'(q_item.slot_shard)),
		.re    (ram_re),
		.raddr (AW'(q_item.rem)),
		.rdata (ram_rdata)
	);

	// table read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else if (q_pop) begin
			rd_v_s1 <= q_item.sel;
		end else if (rd_go) begin
			rd_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re)
			rd_last_s1 <= q_item.last;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (rd_go) begin
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_go) begin
			shard_q <= SHARD_W'(ram_rdata);
			last_q  <= rd_last_s1;
		end
	end

	assign out_ch.valid    = out_v_q;
	assign out_ch.shard_id = shard_q;
	assign out_ch.last_out = last_q;

endmodule

// ===== design/modulo_slot_shard_selector_core.sv =====
// top level of the modulo slot shard selector
// depends on mss_pkg, mss_if, mss_front, mss_fifo, mss_back
//
// Maps each row key to a shard: the key is cut to 8, 16, 32 or 64 bits, reduced modulo the
// configured weight and used to index the slot table. Load transactions fill table entries and
// produce no output; select transactions produce one shard id with the last-row mark. The block
// takes one transaction per cycle while the queue has room. On acceptance an item loads the entry
// register, then passes eight remainder stages of one key byte each, the queue, the registered
// table read and the output register. Throughput is bounded by the back end, which pops one load
// or one select per cycle from the queue unless the output stalls. Write
// configuration only while idle.
module modulo_slot_shard_selector_core import mss_pkg::*; #(
	parameter int SLOT_DEPTH = DEF_SLOT_DEPTH,
	parameter int SHARD_BITS = DEF_SHARD_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [WEIGHT_W-1:0] cfg_wdata,
	mss_in_if.sink              in_ch,
	mss_out_if.source           out_ch
);

	logic [WEIGHT_W-1:0] weight_q;
	logic [1:0]          key_mode_q;
	logic [WEIGHT_W-1:0] weight_eff;
	logic                q_full;
	logic                q_empty;
	logic                q_push;
	logic                q_pop;
	q_item_t             q_in;
	q_item_t             q_out;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q   <= WEIGHT_W'(1);
			key_mode_q <= KEY_MODE_64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WEIGHT_TOTAL:   weight_q   <= cfg_wdata;
				CFG_KEY_WIDTH_MODE: key_mode_q <= cfg_wdata[1:0];
				default:            ;
			endcase
		end
	end

	// zero weight acts as one, weight above the table depth saturates
	always_comb begin
		priority if (weight_q == '0)
			weight_eff = WEIGHT_W'(1);
		else if ({23'd0, weight_q} > SLOT_DEPTH)
			weight_eff = WEIGHT_W'(SLOT_DEPTH);
		else
			weight_eff = weight_q;
	end

	mss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.weight_eff (weight_eff),
		.key_mode   (key_mode_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (q_in)
	);

	mss_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (q_out),
		.empty     (q_empty)
	);

	mss_back #(
		.SLOT_DEPTH (SLOT_DEPTH),
		.SHARD_BITS (SHARD_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_item  (q_out),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule
